// File: rtl/core/ttt_pkg.sv
// ttt_pkg: shared constants, codes and controller/datapath types for the timeout timer table
// used by ttt_ctrl, ttt_dpath and timeout_timer_table; no dependencies
package ttt_pkg;

  localparam int ACTION_W  = 2;
  localparam int TIMEOUT_W = 32;
  localparam int TAG_W     = 32;
  localparam int HANDLE_W  = 4;
  localparam int SLOT_W    = 4;
  localparam int KIND_W    = 3;
  localparam int ORDER_W   = 32;

  // at most this many slots fire on one tick
  localparam int MAX_FIRE = 16;
  localparam int FIRE_W   = 4;

  localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CANCEL   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE_DUE  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCHED_SCAN,
    ST_TICK_SCAN,
    ST_TICK_EVAL
  } ctrl_state_t;

  typedef struct packed {
    logic              capture;
    logic              scan_clear;
    logic              scan_step;
    logic              sched_write;
    logic              time_inc;
    logic              cancel_do;
    logic              fire_take;
    logic              emit;
    logic [KIND_W-1:0] emit_kind;
  } ttt_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                sched_ok;
    logic                slot_free;
    logic                scan_last;
    logic                scan_done;
    logic [1:0]          due_cnt;
    logic                fire_final;
  } ttt_stat_t;

endpackage

// File: rtl/core/ttt_ctrl.sv
// ttt_ctrl: sequencing state machine of the timeout timer table
// drives ttt_dpath through ttt_cmd_t and reads ttt_stat_t; depends on ttt_pkg
module ttt_ctrl import ttt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ttt_cmd_t  cmd,
  input  ttt_stat_t stat
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (stat.action == ACT_SCHEDULE && stat.sched_ok) begin
          state_next = ST_SCHED_SCAN;
        end else if (stat.action == ACT_TICK) begin
          state_next = ST_TICK_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCHED_SCAN: begin
        if (stat.slot_free || stat.scan_last) state_next = ST_IDLE;
      end
      ST_TICK_SCAN: begin
        if (stat.scan_done) state_next = ST_TICK_EVAL;
      end
      ST_TICK_EVAL: begin
        if (stat.due_cnt == 2'd0 || stat.fire_final) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_TICK_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_DECODE: begin
        unique case (stat.action)
          ACT_SCHEDULE: begin
            if (stat.sched_ok) begin
              cmd.scan_clear = 1'b1;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = KIND_REJECTED;
            end
          end
          ACT_CANCEL: begin
            cmd.cancel_do = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_CANCELLED;
          end
          ACT_TICK: begin
            cmd.time_inc   = 1'b1;
            cmd.scan_clear = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SCHED_SCAN: begin
        priority if (stat.slot_free) begin
          cmd.sched_write = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_SCHEDULED;
        end else if (stat.scan_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_REJECTED;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_TICK_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_TICK_EVAL: begin
        if (stat.due_cnt == 2'd0) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_NONE_DUE;
        end else begin
          cmd.fire_take  = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_FIRED;
          cmd.scan_clear = !stat.fire_final;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/ttt_dpath.sv
// ttt_dpath: slot memory, pending bits, time and ordering counters, scan pipeline
// and result registers of the timeout timer table; depends on ttt_pkg
module ttt_dpath import ttt_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ttt_cmd_t             cmd,
  output ttt_stat_t            stat,
  input  logic [ACTION_W-1:0]  action,
  input  logic [TIMEOUT_W-1:0] timeout,
  input  logic                 callback_present,
  input  logic [TAG_W-1:0]     tag,
  input  logic [HANDLE_W-1:0]  handle,
  output logic                 result_strobe,
  output logic [KIND_W-1:0]    kind,
  output logic [SLOT_W-1:0]    slot,
  output logic [TAG_W-1:0]     fired_tag,
  output logic                 removed,
  output logic                 last
);

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRY_W = TIME_BITS + ORDER_W + TAG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // captured transaction
  logic [ACTION_W-1:0]  act_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic                 cb_q;
  logic [TAG_W-1:0]     tag_q;
  logic [HANDLE_W-1:0]  handle_q;

  logic [TIME_BITS-1:0] now;
  logic [ORDER_W-1:0]   insert_count;
  logic [SLOTS-1:0]     pending;
  logic [FIRE_W-1:0]    fire_cnt;

  logic [ENTRY_W-1:0]   mem [SLOTS];
  logic [ENTRY_W-1:0]   rdata;
  logic [ENTRY_W-1:0]   entry_wr;
  logic [TIME_BITS-1:0] deadline_wr;

  // scan pipeline: address issue, memory read, age compute, best update
  logic [IDX_W-1:0]     addr;
  logic                 addr_live;
  logic                 s1_valid;
  logic [IDX_W-1:0]     s1_idx;
  logic                 s2_valid;
  logic [IDX_W-1:0]     s2_idx;
  logic [TIME_BITS-1:0] s2_age;
  logic [ORDER_W-1:0]   s2_order;
  logic [TAG_W-1:0]     s2_tag;
  logic                 s2_due;

  logic                 best_found;
  logic [IDX_W-1:0]     best_idx;
  logic [TIME_BITS-1:0] best_age;
  logic [ORDER_W-1:0]   best_order;
  logic [TAG_W-1:0]     best_tag;
  logic [1:0]           due_cnt;

  logic [TIME_BITS-1:0] rd_deadline;
  logic [ORDER_W-1:0]   rd_order;
  logic [TAG_W-1:0]     rd_tag;
  logic [TIME_BITS-1:0] rd_age;
  logic [ORDER_W-1:0]   order_diff;
  logic                 inserted_earlier;
  logic                 take;
  logic                 fire_final;

  logic [IDX_W+HANDLE_W-1:0] handle_ext;
  logic [IDX_W-1:0]          handle_idx;
  logic                      handle_ok;
  logic                      cancel_hit;
  logic [IDX_W+SLOT_W-1:0]   addr_ext;
  logic [IDX_W+SLOT_W-1:0]   best_ext;

  assign handle_ext = {{IDX_W{1'b0}}, handle_q};
  assign handle_idx = handle_ext[IDX_W-1:0];
  assign handle_ok  = (32'(handle_q) < 32'(SLOTS));
  assign cancel_hit = handle_ok && pending[handle_idx];
  assign addr_ext   = {{SLOT_W{1'b0}}, addr};
  assign best_ext   = {{SLOT_W{1'b0}}, best_idx};

  assign deadline_wr = now + {{(TIME_BITS - TIMEOUT_W){1'b0}}, timeout_q};
  assign entry_wr    = {deadline_wr, insert_count, tag_q};

  assign rd_deadline = rdata[ENTRY_W-1 -: TIME_BITS];
  assign rd_order    = rdata[TAG_W +: ORDER_W];
  assign rd_tag      = rdata[TAG_W-1:0];
  // a slot is due when its age, modulo the time range, is in the lower half
  assign rd_age      = now - rd_deadline;

  assign order_diff       = best_order - s2_order;
  assign inserted_earlier = (order_diff != '0) && !order_diff[ORDER_W-1];
  assign take = !best_found || (s2_age > best_age) ||
                ((s2_age == best_age) && inserted_earlier);

  assign fire_final = (due_cnt == 2'd1) || (fire_cnt == FIRE_W'(MAX_FIRE - 1));

  assign stat.action     = act_q;
  assign stat.sched_ok   = (timeout_q != '0) && cb_q;
  assign stat.slot_free  = !pending[addr];
  assign stat.scan_last  = (addr == LAST_IDX);
  assign stat.scan_done  = !addr_live && !s1_valid && !s2_valid;
  assign stat.due_cnt    = due_cnt;
  assign stat.fire_final = fire_final;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q     <= action;
      timeout_q <= timeout;
      cb_q      <= callback_present;
      tag_q     <= tag;
      handle_q  <= handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now          <= '0;
      insert_count <= '0;
      fire_cnt     <= '0;
    end else begin
      if (cmd.time_inc) now <= now + TIME_BITS'(1);
      if (cmd.sched_write) insert_count <= insert_count + ORDER_W'(1);
      if (cmd.time_inc) begin
        fire_cnt <= '0;
      end else if (cmd.fire_take) begin
        fire_cnt <= fire_cnt + FIRE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      if (cmd.sched_write) pending[addr] <= 1'b1;
      if (cmd.cancel_do && handle_ok) pending[handle_idx] <= 1'b0;
      if (cmd.fire_take) pending[best_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched_write) mem[addr] <= entry_wr;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_live  <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      best_found <= 1'b0;
      due_cnt    <= 2'd0;
    end else if (cmd.scan_clear) begin
      addr_live  <= 1'b1;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      best_found <= 1'b0;
      due_cnt    <= 2'd0;
    end else if (cmd.scan_step) begin
      addr_live <= addr_live && (addr != LAST_IDX);
      s1_valid  <= addr_live;
      s2_valid  <= s1_valid;
      if (s2_valid && s2_due) begin
        // count saturates at two: only "one" versus "more" matters
        due_cnt <= (due_cnt == 2'd2) ? 2'd2 : due_cnt + 2'd1;
        if (take) best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      addr <= '0;
    end else if (cmd.scan_step && addr_live && addr != LAST_IDX) begin
      addr <= addr + IDX_W'(1);
    end
    if (cmd.scan_step) begin
      s1_idx   <= addr;
      s2_idx   <= s1_idx;
      s2_age   <= rd_age;
      s2_order <= rd_order;
      s2_tag   <= rd_tag;
      s2_due   <= pending[s1_idx] && !rd_age[TIME_BITS-1];
      if (s2_valid && s2_due && take) begin
        best_idx   <= s2_idx;
        best_age   <= s2_age;
        best_order <= s2_order;
        best_tag   <= s2_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind      <= cmd.emit_kind;
      slot      <= '0;
      fired_tag <= '0;
      removed   <= 1'b0;
      last      <= 1'b1;
      unique case (cmd.emit_kind)
        KIND_SCHEDULED: slot <= addr_ext[SLOT_W-1:0];
        KIND_FIRED: begin
          slot      <= best_ext[SLOT_W-1:0];
          fired_tag <= best_tag;
          last      <= fire_final;
        end
        KIND_CANCELLED: begin
          slot    <= handle_q;
          removed <= cancel_hit;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sched_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.sched_write |-> !pending[addr])
    else $error("schedule wrote over a pending slot");

  a_fire_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.fire_take |-> (best_found && pending[best_idx]))
    else $error("fired slot was not a found pending slot");

  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.fire_take |=> !pending[$past(best_idx)])
    else $error("fired slot still pending");

  a_fire_needs_due: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_kind == KIND_FIRED) |-> (due_cnt != 2'd0))
    else $error("fire result without a due slot");

  a_strobe_spaced: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("results on consecutive cycles");
`endif

endmodule

// File: rtl/core/timeout_timer_table.sv
// timeout_timer_table: top level of the one-shot timeout table
// joins ttt_ctrl and ttt_dpath; depends on ttt_pkg
//
//   channel   handshake             payload
//   command   start, busy           action timeout callback_present tag handle
//   result    result_strobe         kind slot fired_tag removed last
//
// a transaction is taken when start is high and busy low; busy stays high until its last
// result has been put out. cancel, or a schedule with zero timeout or no callback, is
// answered from decode; any other schedule searches one pending bit per cycle for a free
// slot; tick scans the slot memory one entry a cycle, one scan per fired result and one
// scan when nothing is due; reset is synchronous, no clearing pass.
// each result is shown for one cycle only; the receiver cannot stall it.
module timeout_timer_table import ttt_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [ACTION_W-1:0]  action,
  input  logic [TIMEOUT_W-1:0] timeout,
  input  logic                 callback_present,
  input  logic [TAG_W-1:0]     tag,
  input  logic [HANDLE_W-1:0]  handle,
  output logic                 result_strobe,
  output logic [KIND_W-1:0]    kind,
  output logic [SLOT_W-1:0]    slot,
  output logic [TAG_W-1:0]     fired_tag,
  output logic                 removed,
  output logic                 last
);

  ttt_cmd_t  cmd;
  ttt_stat_t stat;

  ttt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  ttt_dpath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .action           (action),
    .timeout          (timeout),
    .callback_present (callback_present),
    .tag              (tag),
    .handle           (handle),
    .result_strobe    (result_strobe),
    .kind             (kind),
    .slot             (slot),
    .fired_tag        (fired_tag),
    .removed          (removed),
    .last             (last)
  );

endmodule
